// ===== rtl/amec_pkg.sv =====
package amec_pkg;

   localparam int ADDR_W = 64;
   localparam int CNT_W = 64;
   localparam int IDX_W = 2;
   localparam int SHIFT_W = 6;
   localparam int ACT_W = 2;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int MAX_COUNTERS = 3;
   localparam int NUM_COUNTERS_DEF = 3;

   localparam logic [ACT_W-1:0] ACT_TRANS = 2'd0;
   localparam logic [ACT_W-1:0] ACT_EXEC = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_MASK_A = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COMPARE_A = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MASK_B = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COMPARE_B = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MASK_C = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_COMPARE_C = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_SHIFT = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_REPORT_SHIFT = 4'd7;

   localparam logic [ADDR_W-1:0] MASK_A_RST = 64'h0;
   localparam logic [ADDR_W-1:0] COMPARE_A_RST = 64'h0;
   localparam logic [ADDR_W-1:0] MASK_B_RST = 64'h8000_0000_0000_0000;
   localparam logic [ADDR_W-1:0] COMPARE_B_RST = 64'h8000_0000_0000_0000;
   localparam logic [ADDR_W-1:0] MASK_C_RST = 64'h8000_0000_0000_0000;
   localparam logic [ADDR_W-1:0] COMPARE_C_RST = 64'h0;
   localparam logic [SHIFT_W-1:0] SAMPLE_SHIFT_RST = 6'd10;
   localparam logic [SHIFT_W-1:0] REPORT_SHIFT_RST = 6'd28;

   typedef struct packed {
      logic [MAX_COUNTERS-1:0][ADDR_W-1:0] mask;
      logic [MAX_COUNTERS-1:0][ADDR_W-1:0] compare;
      logic [SHIFT_W-1:0] sample_shift;
      logic [SHIFT_W-1:0] report_shift;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic out_free;
   } rpt_ctl_type;

endpackage

// ===== rtl/amec_if.sv =====
interface amec_req_if;
   logic valid;
   logic ready;
   logic [amec_pkg::ACT_W-1:0] action;
   logic [amec_pkg::ADDR_W-1:0] vaddr;

   modport source (output valid, output action, output vaddr, input ready);
   modport sink (input valid, input action, input vaddr, output ready);
endinterface

interface amec_rsp_if;
   logic valid;
   logic ready;
   logic [amec_pkg::IDX_W-1:0] counter_index;
   logic [amec_pkg::CNT_W-1:0] exec_estimate;
   logic [amec_pkg::CNT_W-1:0] trans_total;
   logic last_line;

   modport source (output valid, output counter_index, output exec_estimate,
                   output trans_total, output last_line, input ready);
   modport sink (input valid, input counter_index, input exec_estimate,
                 input trans_total, input last_line, output ready);
endinterface

interface amec_csr_if;
   logic valid;
   logic ready;
   logic [amec_pkg::CSR_INDEX_W-1:0] index;
   logic [amec_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/address_mask_event_counters_top.sv =====
// Channel   Direction  Contents
// req_chan  in         action, vaddr
// rsp_chan  out        counter_index, exec_estimate, trans_total, last_line
// csr_chan  in         index, data (register write, always ready)
//
// Translation and execution events are taken one per cycle except as held below, and update the counts
// in the same cycle. A report is captured in the cycle its transaction is taken and
// leaves as NUM_COUNTERS lines, one per cycle while rsp_chan is ready, from the report buffer.
// A transaction that would start a new report waits while the buffer still holds
// lines other than the one leaving; other events keep flowing during a report.
// Reset is synchronous and clears all counts and restores the register defaults.
module address_mask_event_counters_top #(
   parameter int NUM_COUNTERS = amec_pkg::NUM_COUNTERS_DEF
) (
   input  logic clock,
   input  logic reset,
   amec_req_if.sink req_chan,
   amec_rsp_if.source rsp_chan,
   amec_csr_if.sink csr_chan
);

   amec_pkg::cfg_type cfg;
   amec_pkg::rpt_ctl_type rpt_ctl;
   logic [NUM_COUNTERS-1:0][amec_pkg::CNT_W-1:0] snap_exec;
   logic [NUM_COUNTERS-1:0][amec_pkg::CNT_W-1:0] snap_trans;

   amec_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   amec_counters #(.NUM_COUNTERS(NUM_COUNTERS)) u_counters (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .out_free   (rpt_ctl.out_free),
      .load       (rpt_ctl.load),
      .snap_exec  (snap_exec),
      .snap_trans (snap_trans)
   );

   amec_report #(.NUM_COUNTERS(NUM_COUNTERS)) u_report (
      .clock      (clock),
      .reset      (reset),
      .load       (rpt_ctl.load),
      .snap_exec  (snap_exec),
      .snap_trans (snap_trans),
      .out_free   (rpt_ctl.out_free),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/amec_csr.sv =====
module amec_csr (
   input  logic clock,
   input  logic reset,
   amec_csr_if.sink csr_chan,
   output amec_pkg::cfg_type cfg
);

   amec_pkg::cfg_type cfg_ff;
   amec_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            amec_pkg::REG_MASK_A: cfg_in.mask[0] = csr_chan.data;
            amec_pkg::REG_COMPARE_A: cfg_in.compare[0] = csr_chan.data;
            amec_pkg::REG_MASK_B: cfg_in.mask[1] = csr_chan.data;
            amec_pkg::REG_COMPARE_B: cfg_in.compare[1] = csr_chan.data;
            amec_pkg::REG_MASK_C: cfg_in.mask[2] = csr_chan.data;
            amec_pkg::REG_COMPARE_C: cfg_in.compare[2] = csr_chan.data;
            amec_pkg::REG_SAMPLE_SHIFT:
               cfg_in.sample_shift = csr_chan.data[amec_pkg::SHIFT_W-1:0];
            amec_pkg::REG_REPORT_SHIFT:
               cfg_in.report_shift = csr_chan.data[amec_pkg::SHIFT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mask[0] <= amec_pkg::MASK_A_RST;
         cfg_ff.compare[0] <= amec_pkg::COMPARE_A_RST;
         cfg_ff.mask[1] <= amec_pkg::MASK_B_RST;
         cfg_ff.compare[1] <= amec_pkg::COMPARE_B_RST;
         cfg_ff.mask[2] <= amec_pkg::MASK_C_RST;
         cfg_ff.compare[2] <= amec_pkg::COMPARE_C_RST;
         cfg_ff.sample_shift <= amec_pkg::SAMPLE_SHIFT_RST;
         cfg_ff.report_shift <= amec_pkg::REPORT_SHIFT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/amec_counters.sv =====
module amec_counters #(
   parameter int NUM_COUNTERS = amec_pkg::NUM_COUNTERS_DEF
) (
   input  logic clock,
   input  logic reset,
   amec_req_if.sink req_chan,
   input  amec_pkg::cfg_type cfg,
   input  logic out_free,
   output logic load,
   output logic [NUM_COUNTERS-1:0][amec_pkg::CNT_W-1:0] snap_exec,
   output logic [NUM_COUNTERS-1:0][amec_pkg::CNT_W-1:0] snap_trans
);

   localparam int CW = amec_pkg::CNT_W;

   logic [CW-1:0] event_total_ff, event_total_in;
   logic [NUM_COUNTERS-1:0][CW-1:0] exec_ff, exec_in;
   logic [NUM_COUNTERS-1:0][CW-1:0] trans_ff, trans_in;
   logic [NUM_COUNTERS-1:0][CW-1:0] exec_upd;
   logic [NUM_COUNTERS-1:0] hit;
   logic [CW-1:0] smask, rmask;
   logic do_sample, do_report, is_exec, item_reports, accept;

   always_comb begin
      smask = (CW'(1) << cfg.sample_shift) - CW'(1);
      rmask = (CW'(1) << cfg.report_shift) - CW'(1);
      do_sample = (event_total_ff & smask) == '0;
      do_report = (event_total_ff & rmask) == '0;
      is_exec = req_chan.action == amec_pkg::ACT_EXEC;
      item_reports = (req_chan.action == amec_pkg::ACT_FLUSH) || (is_exec && do_report);
   end

   // A transaction that starts a report waits until the report buffer can take it.
   assign req_chan.ready = !item_reports || out_free;
   assign accept = req_chan.valid && req_chan.ready;
   assign load = accept && item_reports;

   always_comb begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         hit[i] = (req_chan.vaddr & cfg.mask[i]) == cfg.compare[i];
         exec_upd[i] = exec_ff[i] + CW'(hit[i] && do_sample && is_exec);
         snap_exec[i] = exec_upd[i] << cfg.sample_shift;
         snap_trans[i] = trans_ff[i];
      end
   end

   always_comb begin
      event_total_in = event_total_ff;
      exec_in = exec_ff;
      trans_in = trans_ff;
      if (accept) begin
         case (req_chan.action)
            amec_pkg::ACT_TRANS: begin
               for (int i = 0; i < NUM_COUNTERS; i++) begin
                  trans_in[i] = trans_ff[i] + CW'(hit[i]);
               end
            end
            amec_pkg::ACT_EXEC: begin
               event_total_in = event_total_ff + CW'(1);
               exec_in = exec_upd;
               if (do_report) begin
                  exec_in = '0;
                  trans_in = '0;
               end
            end
            amec_pkg::ACT_FLUSH: begin
               exec_in = '0;
               trans_in = '0;
            end
            default: begin
               event_total_in = event_total_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_total_ff <= '0;
         exec_ff <= '0;
         trans_ff <= '0;
      end else begin
         event_total_ff <= event_total_in;
         exec_ff <= exec_in;
         trans_ff <= trans_in;
      end
   end

endmodule

// ===== rtl/amec_report.sv =====
module amec_report #(
   parameter int NUM_COUNTERS = amec_pkg::NUM_COUNTERS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic [NUM_COUNTERS-1:0][amec_pkg::CNT_W-1:0] snap_exec,
   input  logic [NUM_COUNTERS-1:0][amec_pkg::CNT_W-1:0] snap_trans,
   output logic out_free,
   amec_rsp_if.source rsp_chan
);

   localparam int CNT_BITS = $clog2(NUM_COUNTERS + 1);
   localparam int IW = amec_pkg::IDX_W;

   logic [NUM_COUNTERS-1:0][amec_pkg::CNT_W-1:0] exec_ff, exec_in;
   logic [NUM_COUNTERS-1:0][amec_pkg::CNT_W-1:0] trans_ff, trans_in;
   logic [NUM_COUNTERS-1:0][IW-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] left_ff, left_in;
   logic take;

   assign rsp_chan.valid = left_ff != '0;
   assign rsp_chan.counter_index = idx_ff[0];
   assign rsp_chan.exec_estimate = exec_ff[0];
   assign rsp_chan.trans_total = trans_ff[0];
   assign rsp_chan.last_line = left_ff == CNT_BITS'(1);

   assign take = rsp_chan.valid && rsp_chan.ready;
   assign out_free = (left_ff == '0) || (take && rsp_chan.last_line);

   always_comb begin
      exec_in = exec_ff;
      trans_in = trans_ff;
      idx_in = idx_ff;
      left_in = left_ff;
      if (load) begin
         exec_in = snap_exec;
         trans_in = snap_trans;
         for (int i = 0; i < NUM_COUNTERS; i++) begin
            idx_in[i] = IW'(i);
         end
         left_in = CNT_BITS'(NUM_COUNTERS);
      end else if (take) begin
         for (int i = 0; i < NUM_COUNTERS - 1; i++) begin
            exec_in[i] = exec_ff[i + 1];
            trans_in[i] = trans_ff[i + 1];
            idx_in[i] = idx_ff[i + 1];
         end
         left_in = left_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      exec_ff <= exec_in;
      trans_ff <= trans_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

endmodule

// ===== rtl/amec_checker.sv =====
module amec_checker #(
   parameter int NUM_COUNTERS = amec_pkg::NUM_COUNTERS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [amec_pkg::ACT_W-1:0] req_action,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [amec_pkg::IDX_W-1:0] rsp_counter_index,
   input logic rsp_last_line
);

   localparam int IW = amec_pkg::IDX_W;

   // A response line stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped before the transaction completed");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_line |-> rsp_counter_index == IW'(NUM_COUNTERS - 1))
      else $error("last line does not describe the final counter");

   a_next_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_line |=>
         rsp_valid && rsp_counter_index == IW'($past(rsp_counter_index) + IW'(1)))
      else $error("report lines are not contiguous");

   a_flush_report: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == amec_pkg::ACT_FLUSH |=>
         rsp_valid && rsp_counter_index == '0)
      else $error("flush did not start a report at counter zero");

endmodule

bind address_mask_event_counters_top amec_checker #(.NUM_COUNTERS(NUM_COUNTERS)) u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_action        (req_chan.action),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_counter_index (rsp_chan.counter_index),
   .rsp_last_line     (rsp_chan.last_line)
);
